### src/nirfd_pkg.sv
`timescale 1ns / 1ps
package nirfd_pkg;

   // Timer and field widths
   localparam int TIMER_WIDTH   = 16;
   localparam int CAPTURE_WIDTH = 16;
   localparam int CSR_WIDTH     = 16;
   localparam int CMP_WIDTH     = (TIMER_WIDTH > CSR_WIDTH) ? TIMER_WIDTH : CSR_WIDTH;
   localparam int COUNT_WIDTH   = 6;
   localparam int FRAME_WIDTH   = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   // Edge numbering within one frame
   localparam logic [COUNT_WIDTH-1:0] FIRST_DATA_EDGE = COUNT_WIDTH'(3);
   localparam logic [COUNT_WIDTH-1:0] FINAL_EDGE      = COUNT_WIDTH'(34);
   localparam logic [COUNT_WIDTH-1:0] RESTART_EDGE    = COUNT_WIDTH'(1);

   // Register reset values
   localparam logic [CSR_WIDTH-1:0] EXPECTED_ADDRESS_RESET = 16'd0;
   localparam logic [CSR_WIDTH-1:0] ONE_THRESHOLD_RESET    = 16'd1800;
   localparam logic [CSR_WIDTH-1:0] GAP_LIMIT_RESET        = 16'd3000;

   localparam logic [7:0] INVERSE_CHECK = 8'hFF;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_EXPECTED_ADDRESS = 2'd0,
      CSR_ONE_THRESHOLD    = 2'd1,
      CSR_GAP_LIMIT        = 2'd2
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_VALID         = 2'd0,
      STATUS_ADDR_MISMATCH = 2'd1,
      STATUS_INVERSE_FAIL  = 2'd2
   } status_type;

   // Completed frame handed from front to queue, and queue head to back
   typedef struct packed {
      logic                   valid;
      logic [FRAME_WIDTH-1:0] bits;
   } frame_type;

   function automatic logic [7:0] flip_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

### src/nirfd_req_if.sv
`timescale 1ns / 1ps
interface nirfd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] capture_time;

   modport source (output valid, output capture_time, input ready);
   modport sink (input valid, input capture_time, output ready);
endinterface

### src/nirfd_rsp_if.sv
`timescale 1ns / 1ps
interface nirfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  command;
   logic [15:0] address;

   modport source (output valid, output status, output command, output address, input ready);
   modport sink (input valid, input status, input command, input address, output ready);
endinterface

### src/nirfd_front.sv
`timescale 1ns / 1ps
module nirfd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [nirfd_pkg::CAPTURE_WIDTH-1:0] capture_time,
   input  logic [nirfd_pkg::CSR_WIDTH-1:0] one_threshold,
   input  logic [nirfd_pkg::CSR_WIDTH-1:0] gap_limit,
   output nirfd_pkg::frame_type            push
);
   import nirfd_pkg::*;

   logic [TIMER_WIDTH-1:0] prev_time_ff, prev_time_in;
   logic [COUNT_WIDTH-1:0] edge_count_ff, edge_count_in;
   logic [FRAME_WIDTH-1:0] frame_bits_ff, frame_bits_in;

   logic [TIMER_WIDTH-1:0] now;
   logic [TIMER_WIDTH-1:0] interval;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   in_window;
   logic                   gap_hit;
   logic                   data_bit;
   logic [FRAME_WIDTH-1:0] shifted;

   // Interval classification
   always_comb begin
      now       = TIMER_WIDTH'(capture_time);
      interval  = now - prev_time_ff;
      count_inc = edge_count_ff + COUNT_WIDTH'(1);
      in_window = (count_inc >= FIRST_DATA_EDGE) && (count_inc <= FINAL_EDGE);
      gap_hit   = CMP_WIDTH'(interval) > CMP_WIDTH'(gap_limit);
      data_bit  = CMP_WIDTH'(interval) >= CMP_WIDTH'(one_threshold);
      shifted   = {frame_bits_ff[FRAME_WIDTH-2:0], data_bit};
   end

   // Edge counter and bit shifter
   always_comb begin
      prev_time_in  = prev_time_ff;
      edge_count_in = edge_count_ff;
      frame_bits_in = frame_bits_ff;
      push.valid    = 1'b0;
      push.bits     = shifted;
      if (accept) begin
         prev_time_in = now;
         if (in_window && gap_hit) begin
            edge_count_in = RESTART_EDGE;
            frame_bits_in = '0;
         end else if (count_inc == FINAL_EDGE) begin
            edge_count_in = '0;
            frame_bits_in = '0;
            push.valid    = 1'b1;
         end else begin
            edge_count_in = count_inc;
            if (in_window) begin
               frame_bits_in = shifted;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff  <= '0;
         edge_count_ff <= '0;
         frame_bits_ff <= '0;
      end else begin
         prev_time_ff  <= prev_time_in;
         edge_count_ff <= edge_count_in;
         frame_bits_ff <= frame_bits_in;
      end
   end

endmodule

### src/nirfd_queue.sv
`timescale 1ns / 1ps
module nirfd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  nirfd_pkg::frame_type push,
   input  logic                 pop,
   output nirfd_pkg::frame_type head,
   output logic                 full
);
   import nirfd_pkg::*;

   logic [FRAME_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.bits  = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_WIDTH'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_WIDTH'(1);
         2'b01:   count_in = count_ff - QCNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Frame storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.bits;
      end
   end

endmodule

### src/nirfd_back.sv
`timescale 1ns / 1ps
module nirfd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  nirfd_pkg::frame_type            head,
   output logic                            pop,
   input  logic [nirfd_pkg::CSR_WIDTH-1:0] expected_address,
   nirfd_rsp_if.source                     rsp
);
   import nirfd_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  cmd;
   logic [7:0]  inv;
   logic [15:0] addr;

   // Byte split and checks
   always_comb begin
      addr = {flip_byte(head.bits[23:16]), flip_byte(head.bits[31:24])};
      cmd  = flip_byte(head.bits[15:8]);
      inv  = flip_byte(head.bits[7:0]);
      if (addr != expected_address) begin
         status_in = STATUS_ADDR_MISMATCH;
      end else if ((cmd ^ inv) != INVERSE_CHECK) begin
         status_in = STATUS_INVERSE_FAIL;
      end else begin
         status_in = STATUS_VALID;
      end
      command_in = cmd;
      address_in = addr;
   end

   // Output register: load when empty or being drained
   assign pop = head.valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff  <= status_in;
         command_ff <= command_in;
         address_ff <= address_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.status  = status_ff;
   assign rsp.command = command_ff;
   assign rsp.address = address_ff;

endmodule

### src/nec_ir_frame_decoder.sv
`timescale 1ns / 1ps
// A frame completed by its final edge item (FINAL_EDGE) passes through the frame queue into the
// result register on rsp, and waits in the queue while that register is held back.
// Throughput: one edge item per cycle; the front stalls only when the two-entry
// frame queue is full, which needs the result register to be held back.
// Reset (synchronous, active high) clears edge count, last timestamp, frame bits,
// queue pointers, queue count and result valid flag, and loads register defaults.
module nec_ir_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   nirfd_req_if.sink                       req,
   nirfd_rsp_if.source                     rsp,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [nirfd_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import nirfd_pkg::*;

   logic [CSR_WIDTH-1:0] expected_address_ff, expected_address_in;
   logic [CSR_WIDTH-1:0] one_threshold_ff, one_threshold_in;
   logic [CSR_WIDTH-1:0] gap_limit_ff, gap_limit_in;

   frame_type push;
   frame_type head;
   logic      pop;
   logic      full;
   logic      accept;

   // Configuration registers
   always_comb begin
      expected_address_in = expected_address_ff;
      one_threshold_in    = one_threshold_ff;
      gap_limit_in        = gap_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_ADDRESS: expected_address_in = csr_wdata;
            CSR_ONE_THRESHOLD:    one_threshold_in    = csr_wdata;
            CSR_GAP_LIMIT:        gap_limit_in        = csr_wdata;
            default:              ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_address_ff <= EXPECTED_ADDRESS_RESET;
         one_threshold_ff    <= ONE_THRESHOLD_RESET;
         gap_limit_ff        <= GAP_LIMIT_RESET;
      end else begin
         expected_address_ff <= expected_address_in;
         one_threshold_ff    <= one_threshold_in;
         gap_limit_ff        <= gap_limit_in;
      end
   end

   assign req.ready = !full;
   assign accept    = req.valid && !full;

   nirfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .capture_time  (req.capture_time),
      .one_threshold (one_threshold_ff),
      .gap_limit     (gap_limit_ff),
      .push          (push)
   );

   nirfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   nirfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .expected_address (expected_address_ff),
      .rsp              (rsp)
   );

endmodule

### src/nirfd_checker.sv
`timescale 1ns / 1ps
module nirfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_command,
   input logic [15:0] rsp_address
);
   import nirfd_pkg::*;

   // No result may be pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Status carries only the three defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_VALID || rsp_status == STATUS_ADDR_MISMATCH ||
                     rsp_status == STATUS_INVERSE_FAIL))
      else $error("undefined status code");

   // Input side is open whenever nothing is waiting on the output
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(rsp_valid) && !$past(reset) |-> req_ready)
      else $error("input stalled with empty output");

   // Stalled result keeps its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_command) && $stable(rsp_address))
      else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder nirfd_checker u_nirfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_status  (rsp.status),
   .rsp_command (rsp.command),
   .rsp_address (rsp.address)
);
